@@ hw/rtl/tfn_pkg.sv @@
// Shared types, constants and register codes for the triangle face normal block.
// Used by every module under hw/rtl; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package tfn_pkg;

	// Fixed field widths of the ports.
	localparam int COORD_W = 32;
	localparam int INDEX_W = 16;
	localparam int NRM_W   = 16;

	// Defaults for the top-level parameters.
	localparam int DEF_COORD_WIDTH = 32;
	localparam int DEF_INDEX_WIDTH = 16;

	// Normalized component width, square root and division widths.
	localparam int NORM_W     = 30;
	localparam int ROOT_W     = NORM_W + 1;
	localparam int FRAC_W     = NRM_W - 1;
	localparam int Q_W        = NRM_W;
	localparam logic [Q_W-1:0] MAX_Q = Q_W'((1 << FRAC_W) - 1);

	// Configuration port.
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 1;
	localparam logic [CFG_IDX_W-1:0] REG_ENABLE       = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_VERTEX_COUNT = 1'd1;
	localparam logic                 ENABLE_RST       = 1'b1;
	localparam logic [INDEX_W-1:0]   VCOUNT_RST       = 16'hFFFF;

	// Corner codes of the result serializer.
	localparam logic [1:0] CORNER_A = 2'd0;
	localparam logic [1:0] CORNER_B = 2'd1;
	localparam logic [1:0] CORNER_C = 2'd2;

	typedef struct packed {
		logic signed [COORD_W-1:0] a_x;
		logic signed [COORD_W-1:0] a_y;
		logic signed [COORD_W-1:0] a_z;
		logic signed [COORD_W-1:0] b_x;
		logic signed [COORD_W-1:0] b_y;
		logic signed [COORD_W-1:0] b_z;
		logic signed [COORD_W-1:0] c_x;
		logic signed [COORD_W-1:0] c_y;
		logic signed [COORD_W-1:0] c_z;
		logic [INDEX_W-1:0]        index_a;
		logic [INDEX_W-1:0]        index_b;
		logic [INDEX_W-1:0]        index_c;
	} item_t;

	typedef struct packed {
		logic [INDEX_W-1:0]      vertex_index;
		logic signed [NRM_W-1:0] normal_x;
		logic signed [NRM_W-1:0] normal_y;
		logic signed [NRM_W-1:0] normal_z;
		logic                    degenerate;
		logic                    index_out_of_range;
		logic                    last_corner;
	} result_t;

	// Corner indices that travel with a triangle.
	typedef struct packed {
		logic [INDEX_W-1:0] index_a;
		logic [INDEX_W-1:0] index_b;
		logic [INDEX_W-1:0] index_c;
	} side_t;

	// Normalized cross product with signs.
	typedef struct packed {
		logic [2:0][NORM_W-1:0] m;
		logic [2:0]             neg;
		logic                   degen;
		side_t                  side;
	} vec_t;

	// Final normal of one triangle.
	typedef struct packed {
		logic [2:0][NRM_W-1:0] n;
		logic                  degen;
		side_t                 side;
	} nrm_t;

endpackage

`default_nettype wire

@@ hw/rtl/triangle_face_normal.sv @@
// Top level of the triangle face normal block: registers, throttle and the
// corner serializer. Depends on tfn_pkg, tfn_cross, tfn_root and tfn_div.
//
//   Channel   Handshake              Payload           Direction
//   triangle  start, busy            item (item_t)     in
//   corner    result_valid strobe    result (result_t) out
//   config    cfg_write              cfg_index, cfg_data  in
//
// A triangle is taken at an edge with start high and busy low; busy then
// stays high until the throttle count runs down; a new triangle can enter
// while earlier ones are in the pipeline. The three corner beats follow on
// consecutive cycles; the depth is set by the cross stages, the 16-stage
// square root and the 8-stage divider. The receiver cannot stall, so
// nothing backs up. Reset clears the control state and sets enable to
// 1 and vertex_count to 65535; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module triangle_face_normal #(
	parameter int COORD_WIDTH = tfn_pkg::DEF_COORD_WIDTH,
	parameter int INDEX_WIDTH = tfn_pkg::DEF_INDEX_WIDTH
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               start,
	input  wire tfn_pkg::item_t                     item,
	output logic                                    busy,
	input  wire logic                               cfg_write,
	input  wire logic [tfn_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [tfn_pkg::CFG_DATA_W-1:0]     cfg_data,
	output logic                                    result_valid,
	output tfn_pkg::result_t                        result
);

	localparam int IW = tfn_pkg::INDEX_W;
	localparam logic [IW-1:0] IDX_MASK =
		(INDEX_WIDTH >= IW) ? {IW{1'b1}} : IW'((64'd1 << INDEX_WIDTH) - 64'd1);

	logic                 enable_q;
	logic [IW-1:0]        vcount_q;
	logic [1:0]           gap_q;
	logic                 accept;
	tfn_pkg::side_t       side_c;

	logic                 cross_valid, root_valid, div_valid;
	tfn_pkg::vec_t        cross_vec, root_vec;
	logic [tfn_pkg::ROOT_W-1:0] root_len;
	tfn_pkg::nrm_t        div_nrm;

	tfn_pkg::nrm_t        hold_q;
	logic [1:0]           corner_q;
	logic                 active_q;
	logic [IW-1:0]        idx_c;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= tfn_pkg::ENABLE_RST;
			vcount_q <= tfn_pkg::VCOUNT_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				tfn_pkg::REG_ENABLE:       enable_q <= cfg_data[0];
				tfn_pkg::REG_VERTEX_COUNT: vcount_q <= cfg_data[IW-1:0];
				default: ;
			endcase
		end
	end

	// Busy closes the input after each accepted triangle to keep pace with the corner beats.
	assign accept = start && !busy;
	assign busy   = (gap_q != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_q <= 2'd0;
		end else if (accept) begin
			gap_q <= 2'd2;
		end else if (gap_q != 2'd0) begin
			gap_q <= gap_q - 2'd1;
		end
	end

	assign side_c.index_a = item.index_a & IDX_MASK;
	assign side_c.index_b = item.index_b & IDX_MASK;
	assign side_c.index_c = item.index_c & IDX_MASK;

	tfn_cross #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_cross (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (accept && enable_q),
		.item     (item),
		.in_side  (side_c),
		.out_valid(cross_valid),
		.vec      (cross_vec)
	);

	tfn_root u_root (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (cross_valid),
		.in_vec   (cross_vec),
		.out_valid(root_valid),
		.out_vec  (root_vec),
		.len      (root_len)
	);

	tfn_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (root_valid),
		.in_vec   (root_vec),
		.len      (root_len),
		.out_valid(div_valid),
		.nrm      (div_nrm)
	);

	// Corner serializer: three beats per finished triangle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			corner_q <= tfn_pkg::CORNER_A;
		end else if (div_valid) begin
			active_q <= 1'b1;
			corner_q <= tfn_pkg::CORNER_A;
		end else if (active_q) begin
			if (corner_q == tfn_pkg::CORNER_C) begin
				active_q <= 1'b0;
			end else begin
				corner_q <= corner_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (div_valid) begin
			hold_q <= div_nrm;
		end
	end

	always_comb begin
		case (corner_q)
			tfn_pkg::CORNER_A: idx_c = hold_q.side.index_a;
			tfn_pkg::CORNER_B: idx_c = hold_q.side.index_b;
			tfn_pkg::CORNER_C: idx_c = hold_q.side.index_c;
			default:           idx_c = hold_q.side.index_c;
		endcase
	end

	assign result_valid              = active_q;
	assign result.vertex_index       = idx_c;
	assign result.normal_x           = hold_q.n[0];
	assign result.normal_y           = hold_q.n[1];
	assign result.normal_z           = hold_q.n[2];
	assign result.degenerate         = hold_q.degen;
	assign result.index_out_of_range = (idx_c >= vcount_q);
	assign result.last_corner        = (corner_q == tfn_pkg::CORNER_C);

	// A triangle's beats come back to back.
	a_beats_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.last_corner |=> result_valid)
		else $error("corner beats of a triangle were split");

	// The normal holds across the corners of one triangle.
	a_normal_stable: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.last_corner |=>
			result.normal_x == $past(result.normal_x) &&
			result.normal_y == $past(result.normal_y) &&
			result.normal_z == $past(result.normal_z))
		else $error("normal changed within a triangle");

	// A degenerate triangle carries a zero normal.
	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.degenerate |->
			result.normal_x == '0 && result.normal_y == '0 && result.normal_z == '0)
		else $error("degenerate triangle with nonzero normal");

	// Accepting a triangle closes the input while the throttle count runs down.
	a_throttle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy ##1 busy)
		else $error("input reopened too early");

endmodule

`default_nettype wire

@@ hw/rtl/tfn_cross.sv @@
// Edge differences, cross product and block normalization to 30-bit magnitudes.
// Depends on tfn_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tfn_cross #(
	parameter int COORD_WIDTH = tfn_pkg::DEF_COORD_WIDTH
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	input  wire tfn_pkg::item_t item,
	input  wire tfn_pkg::side_t in_side,
	output logic                out_valid,
	output tfn_pkg::vec_t       vec
);

	localparam int CW = COORD_WIDTH;
	localparam int EW = CW + 1;
	localparam int PW = 2 * CW + 2;
	localparam int MW = 2 * CW + 1;
	localparam int LW = $clog2(MW + 1);
	localparam int SW = MW + tfn_pkg::NORM_W;

	logic [2:0][CW-1:0] a_c, b_c, c_c;

	logic [5:0]               vld_q;
	logic signed [EW-1:0]     e1_s1 [3];
	logic signed [EW-1:0]     e2_s1 [3];
	logic signed [PW-1:0]     p_s2  [6];
	logic signed [PW-1:0]     cr_s3 [3];
	logic [MW-1:0]            mag_s4 [3];
	logic [MW-1:0]            mag_s5 [3];
	logic [2:0]               neg_s4, neg_s5;
	logic [LW-1:0]            len_s5;
	tfn_pkg::side_t           side_s1, side_s2, side_s3, side_s4, side_s5;
	tfn_pkg::vec_t            vec_s6;

	logic [MW-1:0]                     or_c;
	logic [LW-1:0]                     len_c;
	logic [2:0][tfn_pkg::NORM_W-1:0]   m_c;

	// Coordinates narrowed to the configured width.
	assign a_c[0] = item.a_x[CW-1:0];
	assign a_c[1] = item.a_y[CW-1:0];
	assign a_c[2] = item.a_z[CW-1:0];
	assign b_c[0] = item.b_x[CW-1:0];
	assign b_c[1] = item.b_y[CW-1:0];
	assign b_c[2] = item.b_z[CW-1:0];
	assign c_c[0] = item.c_x[CW-1:0];
	assign c_c[1] = item.c_y[CW-1:0];
	assign c_c[2] = item.c_z[CW-1:0];

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[4:0], in_valid};
		end
	end

	// Stages one to three: edges, six products, component differences.
	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			e1_s1[k] <= EW'($signed(b_c[k])) - EW'($signed(a_c[k]));
			e2_s1[k] <= EW'($signed(c_c[k])) - EW'($signed(a_c[k]));
		end
		side_s1 <= in_side;

		p_s2[0] <= e1_s1[1] * e2_s1[2];
		p_s2[1] <= e1_s1[2] * e2_s1[1];
		p_s2[2] <= e1_s1[2] * e2_s1[0];
		p_s2[3] <= e1_s1[0] * e2_s1[2];
		p_s2[4] <= e1_s1[0] * e2_s1[1];
		p_s2[5] <= e1_s1[1] * e2_s1[0];
		side_s2 <= side_s1;

		for (int k = 0; k < 3; k++) begin
			cr_s3[k] <= p_s2[2 * k] - p_s2[2 * k + 1];
		end
		side_s3 <= side_s2;
	end

	// Stage four: sign and magnitude.
	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			mag_s4[k] <= cr_s3[k][PW-1] ? MW'(-cr_s3[k]) : MW'(cr_s3[k]);
			neg_s4[k] <= cr_s3[k][PW-1];
		end
		side_s4 <= side_s3;
	end

	// Stage five: bit length of the largest magnitude.
	always_comb begin
		or_c  = mag_s4[0] | mag_s4[1] | mag_s4[2];
		len_c = '0;
		for (int i = 0; i < MW; i++) begin
			if (or_c[i]) begin
				len_c = LW'(i + 1);
			end
		end
	end

	always_ff @(posedge clk) begin
		mag_s5  <= mag_s4;
		neg_s5  <= neg_s4;
		len_s5  <= len_c;
		side_s5 <= side_s4;
	end

	// Stage six: shift all three so the largest lands in [2^29, 2^30).
	always_comb begin
		logic [SW-1:0] sh;
		for (int k = 0; k < 3; k++) begin
			sh = {mag_s5[k], {tfn_pkg::NORM_W{1'b0}}} >> len_s5;
			m_c[k] = sh[tfn_pkg::NORM_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		vec_s6.m     <= m_c;
		vec_s6.neg   <= neg_s5;
		vec_s6.degen <= (len_s5 == '0);
		vec_s6.side  <= side_s5;
	end

	assign out_valid = vld_q[5];
	assign vec       = vec_s6;

endmodule

`default_nettype wire

@@ hw/rtl/tfn_root.sv @@
// Sum of squares and a pipelined integer square root, two root bits per stage.
// Depends on tfn_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tfn_root (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	input  wire tfn_pkg::vec_t in_vec,
	output logic               out_valid,
	output tfn_pkg::vec_t      out_vec,
	output logic [tfn_pkg::ROOT_W-1:0] len
);

	localparam int NW    = tfn_pkg::NORM_W;
	localparam int STEPS = tfn_pkg::ROOT_W;
	localparam int RAD_W = 2 * STEPS;
	localparam int REM_W = STEPS + 3;
	localparam int PER   = 2;
	localparam int RSTG  = (STEPS + PER - 1) / PER;

	logic                 vld_s1;
	logic [2*NW-1:0]      sq_s1 [3];
	tfn_pkg::vec_t        vec_s1;

	logic [RSTG:0]        vld_s;
	logic [REM_W-1:0]     rem_s  [RSTG+1];
	logic [STEPS-1:0]     root_s [RSTG+1];
	logic [RAD_W-1:0]     rad_s  [RSTG+1];
	tfn_pkg::vec_t        vec_s  [RSTG+1];

	// Squares, then their sum seeds the root pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1   <= 1'b0;
			vld_s[0] <= 1'b0;
		end else begin
			vld_s1   <= in_valid;
			vld_s[0] <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			sq_s1[k] <= in_vec.m[k] * in_vec.m[k];
		end
		vec_s1    <= in_vec;
		rad_s[0]  <= RAD_W'(sq_s1[0]) + RAD_W'(sq_s1[1]) + RAD_W'(sq_s1[2]);
		rem_s[0]  <= '0;
		root_s[0] <= '0;
		vec_s[0]  <= vec_s1;
	end

	// Digit-by-digit root stages.
	for (genvar g = 0; g < RSTG; g++) begin : g_stage
		logic [REM_W-1:0] rem_n;
		logic [STEPS-1:0] root_n;
		logic [RAD_W-1:0] rad_n;

		always_comb begin
			logic [REM_W-1:0] trial;
			rem_n  = rem_s[g];
			root_n = root_s[g];
			rad_n  = rad_s[g];
			for (int j = 0; j < PER; j++) begin
				if (g * PER + j < STEPS) begin
					rem_n = {rem_n[REM_W-3:0], rad_n[RAD_W-1 -: 2]};
					rad_n = {rad_n[RAD_W-3:0], 2'b00};
					trial = REM_W'({root_n, 2'b01});
					if (rem_n >= trial) begin
						rem_n  = rem_n - trial;
						root_n = {root_n[STEPS-2:0], 1'b1};
					end else begin
						root_n = {root_n[STEPS-2:0], 1'b0};
					end
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g+1] <= 1'b0;
			end else begin
				vld_s[g+1] <= vld_s[g];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[g+1]  <= rem_n;
			root_s[g+1] <= root_n;
			rad_s[g+1]  <= rad_n;
			vec_s[g+1]  <= vec_s[g];
		end
	end

	assign out_valid = vld_s[RSTG];
	assign out_vec   = vec_s[RSTG];
	assign len       = root_s[RSTG];

endmodule

`default_nettype wire

@@ hw/rtl/tfn_div.sv @@
// Three-lane pipelined rounding divider: component * 2^15 / length, with
// saturation and sign. Depends on tfn_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tfn_div (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	input  wire tfn_pkg::vec_t               in_vec,
	input  wire logic [tfn_pkg::ROOT_W-1:0]  len,
	output logic                             out_valid,
	output tfn_pkg::nrm_t                    nrm
);

	localparam int NW     = tfn_pkg::NORM_W;
	localparam int QW     = tfn_pkg::Q_W;
	localparam int FW     = tfn_pkg::FRAC_W;
	localparam int LEN_W  = tfn_pkg::ROOT_W;
	localparam int NUM_W  = NW + FW + 1;
	localparam int REMD_W = LEN_W + 1;
	localparam int PER    = 2;
	localparam int DSTG   = (QW + PER - 1) / PER;

	logic [DSTG:0]              vld_s;
	logic [2:0][REMD_W-1:0]     r_s   [DSTG+1];
	logic [2:0][QW-1:0]         low_s [DSTG+1];
	logic [2:0][QW-1:0]         q_s   [DSTG+1];
	logic [LEN_W-1:0]           len_s [DSTG+1];
	tfn_pkg::vec_t              vec_s [DSTG+1];
	logic                       vld_out_q;
	tfn_pkg::nrm_t              nrm_q;

	logic [2:0][NUM_W-1:0]      num_c;

	// Rounded numerator; its top bits are already below the length.
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			num_c[k] = NUM_W'({in_vec.m[k], {FW{1'b0}}}) + NUM_W'(len >> 1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s     <= '0;
			vld_out_q <= 1'b0;
		end else begin
			vld_s     <= {vld_s[DSTG-1:0], in_valid};
			vld_out_q <= vld_s[DSTG];
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			r_s[0][k]   <= REMD_W'(num_c[k][NUM_W-1:QW]);
			low_s[0][k] <= num_c[k][QW-1:0];
			q_s[0][k]   <= '0;
		end
		len_s[0] <= len;
		vec_s[0] <= in_vec;
	end

	// Restoring division stages, two quotient bits each.
	for (genvar g = 0; g < DSTG; g++) begin : g_stage
		logic [2:0][REMD_W-1:0] r_n;
		logic [2:0][QW-1:0]     low_n;
		logic [2:0][QW-1:0]     q_n;

		always_comb begin
			r_n   = r_s[g];
			low_n = low_s[g];
			q_n   = q_s[g];
			for (int k = 0; k < 3; k++) begin
				for (int j = 0; j < PER; j++) begin
					if (g * PER + j < QW) begin
						r_n[k]   = {r_n[k][REMD_W-2:0], low_n[k][QW-1]};
						low_n[k] = {low_n[k][QW-2:0], 1'b0};
						if (r_n[k] >= REMD_W'(len_s[g])) begin
							r_n[k] = r_n[k] - REMD_W'(len_s[g]);
							q_n[k] = {q_n[k][QW-2:0], 1'b1};
						end else begin
							q_n[k] = {q_n[k][QW-2:0], 1'b0};
						end
					end
				end
			end
		end

		always_ff @(posedge clk) begin
			r_s[g+1]   <= r_n;
			low_s[g+1] <= low_n;
			q_s[g+1]   <= q_n;
			len_s[g+1] <= len_s[g];
			vec_s[g+1] <= vec_s[g];
		end
	end

	// Saturate, apply the sign, and zero a degenerate triangle.
	always_ff @(posedge clk) begin
		logic [QW-1:0] sat;
		for (int k = 0; k < 3; k++) begin
			sat = (q_s[DSTG][k] > tfn_pkg::MAX_Q) ? tfn_pkg::MAX_Q : q_s[DSTG][k];
			if (vec_s[DSTG].degen) begin
				nrm_q.n[k] <= '0;
			end else if (vec_s[DSTG].neg[k]) begin
				nrm_q.n[k] <= QW'(-sat);
			end else begin
				nrm_q.n[k] <= sat;
			end
		end
		nrm_q.degen <= vec_s[DSTG].degen;
		nrm_q.side  <= vec_s[DSTG].side;
	end

	assign out_valid = vld_out_q;
	assign nrm       = nrm_q;

endmodule

`default_nettype wire

@@ bench/triangle_face_normal_test.sv @@
// Self-checking bench for the triangle face normal block: random and directed triangles,
// register phases and an exact integer predictor of the corner beats. Depends on tfn_pkg.
`timescale 1ns / 1ps

module triangle_face_normal_test;

	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 50;

	// One entry of the pending stimulus: a triangle or a register write.
	typedef struct {
		bit                                is_cfg;
		logic [tfn_pkg::CFG_IDX_W-1:0]     idx;
		logic [tfn_pkg::CFG_DATA_W-1:0]    data;
		tfn_pkg::item_t                    shape;
		bit                                calm;
	} pending_t;

	logic clk, arst_n, start, busy, cfg_write, result_valid;
	logic [tfn_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [tfn_pkg::CFG_DATA_W-1:0] cfg_data;
	tfn_pkg::item_t item;
	tfn_pkg::result_t result;

	pending_t pending_q[$];
	tfn_pkg::result_t corner_q[$];
	bit model_enable;
	logic [tfn_pkg::INDEX_W-1:0] model_vcount;
	bit taken;
	int quiet, cycles, gap, failures;
	bit stim_done;

	triangle_face_normal dut (
		.clk(clk), .arst_n(arst_n), .start(start), .item(item), .busy(busy),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.result_valid(result_valid), .result(result)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// Integer square root, floor, on 64 bits.
	function automatic logic [63:0] isqrt(logic [63:0] v);
		logic [63:0] res, bitv;
		res = 0;
		bitv = 64'h4000_0000_0000_0000;
		while (bitv > v) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v = v - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	// Expected corner beats of one triangle under the current registers.
	task automatic predict_corners(tfn_pkg::item_t t);
		logic signed [32:0] e1[3], e2[3];
		logic signed [69:0] cr[3];
		logic [66:0] mag[3];
		logic [63:0] m[3], sum, len, q;
		logic [15:0] nrm[3];
		logic [15:0] idx[3];
		int blen, maxlen, shift;
		bit degen;
		tfn_pkg::result_t r;
		if (!model_enable) return;
		e1[0] = 33'(t.b_x) - 33'(t.a_x);
		e1[1] = 33'(t.b_y) - 33'(t.a_y);
		e1[2] = 33'(t.b_z) - 33'(t.a_z);
		e2[0] = 33'(t.c_x) - 33'(t.a_x);
		e2[1] = 33'(t.c_y) - 33'(t.a_y);
		e2[2] = 33'(t.c_z) - 33'(t.a_z);
		cr[0] = 70'(e1[1]) * 70'(e2[2]) - 70'(e1[2]) * 70'(e2[1]);
		cr[1] = 70'(e1[2]) * 70'(e2[0]) - 70'(e1[0]) * 70'(e2[2]);
		cr[2] = 70'(e1[0]) * 70'(e2[1]) - 70'(e1[1]) * 70'(e2[0]);
		maxlen = 0;
		for (int i = 0; i < 3; i++) begin
			mag[i] = cr[i] < 0 ? 67'(-cr[i]) : 67'(cr[i]);
			// Any magnitude past 64 bits counts as 65 bits long.
			if (mag[i][66:64] != 0) begin
				blen = 65;
			end else begin
				blen = 0;
				for (int b = 0; b < 64; b++) if (mag[i][b]) blen = b + 1;
			end
			if (blen > maxlen) maxlen = blen;
		end
		degen = (maxlen == 0);
		nrm = '{0, 0, 0};
		if (!degen) begin
			shift = maxlen - 30;
			sum = 0;
			for (int i = 0; i < 3; i++) begin
				if (shift > 0) m[i] = 64'(mag[i] >> shift);
				else m[i] = mag[i][63:0] << (-shift);
				sum = sum + m[i] * m[i];
			end
			len = isqrt(sum);
			for (int i = 0; i < 3; i++) begin
				q = ((m[i] << 15) + (len >> 1)) / len;
				if (q > 64'd32767) q = 64'd32767;
				nrm[i] = cr[i] < 0 ? 16'(-q) : 16'(q);
			end
		end
		idx = '{t.index_a, t.index_b, t.index_c};
		for (int k = 0; k < 3; k++) begin
			r.vertex_index = idx[k];
			r.normal_x = nrm[0];
			r.normal_y = nrm[1];
			r.normal_z = nrm[2];
			r.degenerate = degen;
			r.index_out_of_range = idx[k] >= model_vcount;
			r.last_corner = (k == 2);
			corner_q = {corner_q, r};
		end
	endtask

	// Monitor: register shadow, acceptance, result checks and the timeout.
	always @(posedge clk) begin
		tfn_pkg::result_t exp_r;
		if (arst_n) begin
			cycles <= cycles + 1;
			if (cycles > CYCLE_LIMIT) begin
				$display("** triangle_face_normal: FAILED **");
				$finish;
			end else begin
				if (cfg_write) begin
					if (cfg_index == tfn_pkg::REG_ENABLE) model_enable = cfg_data[0];
					else if (cfg_index == tfn_pkg::REG_VERTEX_COUNT) model_vcount = cfg_data;
				end
				taken = start && !busy;
				if (taken) predict_corners(item);
				if (result_valid) begin
					if (corner_q.size() == 0) begin
						$error("corner beat with nothing expected");
						failures++;
					end else begin
						exp_r = corner_q.pop_front();
						if (result.vertex_index !== exp_r.vertex_index) begin
							$error("vertex_index exp %0d got %0d", exp_r.vertex_index,
								result.vertex_index);
							failures++;
						end
						if (result.normal_x !== exp_r.normal_x) begin
							$error("normal_x exp %0d got %0d", exp_r.normal_x, result.normal_x);
							failures++;
						end
						if (result.normal_y !== exp_r.normal_y) begin
							$error("normal_y exp %0d got %0d", exp_r.normal_y, result.normal_y);
							failures++;
						end
						if (result.normal_z !== exp_r.normal_z) begin
							$error("normal_z exp %0d got %0d", exp_r.normal_z, result.normal_z);
							failures++;
						end
						if (result.degenerate !== exp_r.degenerate) begin
							$error("degenerate exp %0d got %0d", exp_r.degenerate,
								result.degenerate);
							failures++;
						end
						if (result.index_out_of_range !== exp_r.index_out_of_range) begin
							$error("index_out_of_range exp %0d got %0d",
								exp_r.index_out_of_range, result.index_out_of_range);
							failures++;
						end
						if (result.last_corner !== exp_r.last_corner) begin
							$error("last_corner exp %0d got %0d", exp_r.last_corner,
								result.last_corner);
							failures++;
						end
					end
				end
				quiet <= (corner_q.size() == 0 && !start && !taken) ? quiet + 1 : 0;
			end
		end
	end

	// Driver: one assignment per signal per falling edge.
	always @(negedge clk) begin
		pending_t p;
		bit nx_start, nx_write;
		nx_start = start;
		nx_write = 0;
		if (arst_n) begin
			if (start && !taken) begin
				nx_start = 1;
			end else if (gap > 0) begin
				gap <= gap - 1;
				nx_start = 0;
			end else if (pending_q.size() == 0) begin
				nx_start = 0;
			end else if (pending_q[0].is_cfg) begin
				nx_start = 0;
				// Registers change only once the block has drained.
				if (quiet >= DRAIN_CYCLES) begin
					p = pending_q.pop_front();
					nx_write = 1;
					cfg_index <= p.idx;
					cfg_data <= p.data;
				end
			end else begin
				p = pending_q.pop_front();
				nx_start = 1;
				item <= p.shape;
				if (!p.calm && $urandom_range(0, 3) == 0) gap <= $urandom_range(1, 7);
			end
			if (!nx_start && !nx_write && pending_q.size() == 0 && !start) stim_done = 1;
		end
		start <= nx_start;
		cfg_write <= nx_write;
	end

	function automatic logic [31:0] rand_coord(int mode);
		case (mode)
			0: return $urandom;
			1: return 32'($signed($urandom_range(0, 2 ** 21)) - 2 ** 20);
			default: return 32'($signed($urandom_range(0, 64)) - 32);
		endcase
	endfunction

	task automatic add_tri(logic [31:0] ax, ay, az, bx, by, bz, cx, cy, cz,
			logic [15:0] ia, ib, ic, bit calm);
		pending_t p;
		p.is_cfg = 0;
		p.idx = '0;
		p.data = '0;
		p.calm = calm;
		p.shape = '{ax, ay, az, bx, by, bz, cx, cy, cz, ia, ib, ic};
		pending_q = {pending_q, p};
	endtask

	task automatic add_write(logic [tfn_pkg::CFG_IDX_W-1:0] idx,
			logic [tfn_pkg::CFG_DATA_W-1:0] data);
		pending_t p;
		p.is_cfg = 1;
		p.idx = idx;
		p.data = data;
		p.calm = 0;
		p.shape = '0;
		pending_q = {pending_q, p};
	endtask

	task automatic add_random(int n, bit calm);
		logic [31:0] a[3];
		int mode;
		for (int i = 0; i < n; i++) begin
			mode = $urandom_range(0, 2);
			for (int j = 0; j < 3; j++) a[j] = rand_coord(mode);
			if ($urandom_range(0, 4) == 0) begin
				// Small triangle close to vertex a.
				add_tri(a[0], a[1], a[2], a[0] + rand_coord(2), a[1] + rand_coord(2),
					a[2] + rand_coord(2), a[0] + rand_coord(2), a[1] + rand_coord(2),
					a[2] + rand_coord(2), 16'($urandom), 16'($urandom), 16'($urandom),
					calm);
			end else begin
				add_tri(a[0], a[1], a[2], rand_coord(mode), rand_coord(mode),
					rand_coord(mode), rand_coord(mode), rand_coord(mode), rand_coord(mode),
					16'($urandom), 16'($urandom), 16'($urandom), calm);
			end
		end
	endtask

	// Stimulus plan and the end of the run.
	initial begin
		logic [31:0] one, mx, mn;
		one = 32'h0001_0000;
		mx = 32'h7FFF_FFFF;
		mn = 32'h8000_0000;
		arst_n = 0;
		start = 0;
		cfg_write = 0;
		cfg_index = '0;
		cfg_data = '0;
		item = '0;
		model_enable = tfn_pkg::ENABLE_RST;
		model_vcount = tfn_pkg::VCOUNT_RST;
		taken = 0;
		quiet = 0;
		cycles = 0;
		gap = 0;
		failures = 0;
		stim_done = 0;

		// Directed: degenerate, axis normals, extremes, index edges.
		add_tri(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 2, 0);
		add_tri(0, 0, 0, one, one, one, 2 * one, 2 * one, 2 * one, 3, 4, 5, 0);
		add_tri(0, 0, 0, one, 0, 0, 0, one, 0, 16'hFFFF, 16'hFFFE, 0, 0);
		add_tri(0, 0, 0, 0, one, 0, one, 0, 0, 7, 8, 9, 0);
		add_tri(0, 0, 0, 0, 0, one, 0, one, 0, 7, 8, 9, 0);
		add_tri(mn, mn, mn, mx, mn, mn, mn, mx, mn, 0, 16'hFFFF, 1, 0);
		add_tri(mn, mn, mn, mx, mx, mn, mn, mx, mx, 1, 2, 3, 0);
		add_tri(mx, mx, mx, mn, mn, mx, mx, mn, mn, 4, 5, 6, 0);
		add_tri(mn, mx, mn, mx, mn, mx, mn, mn, mx, 10, 11, 12, 0);
		add_tri(0, 0, 0, 1, 0, 0, 0, 1, 0, 13, 14, 15, 0);
		add_tri(0, 0, 0, 1, 1, 0, 1, 2, 1, 13, 14, 15, 0);
		add_tri(mx, mx, mx, mx, mx, mx, mn, mn, mn, 1, 1, 1, 0);
		add_write(tfn_pkg::REG_VERTEX_COUNT, 16'd0);
		add_tri(0, 0, 0, one, 0, 0, 0, 0, one, 0, 1, 16'hFFFF, 0);
		add_write(tfn_pkg::REG_VERTEX_COUNT, 16'd100);
		add_tri(0, 0, 0, one, 0, 0, 0, 0, one, 99, 100, 101, 0);
		add_write(tfn_pkg::REG_ENABLE, 16'd0);
		add_tri(0, 0, 0, one, 0, 0, 0, one, 0, 1, 2, 3, 0);
		add_random(4, 0);
		add_write(tfn_pkg::REG_ENABLE, 16'd1);
		add_write(tfn_pkg::REG_VERTEX_COUNT, 16'hFFFF);

		// Random phases across register settings.
		add_random(50, 0);
		add_write(tfn_pkg::REG_VERTEX_COUNT, 16'($urandom));
		add_random(40, 0);
		add_write(tfn_pkg::REG_VERTEX_COUNT, 16'h8000);
		add_random(30, 0);
		add_write(tfn_pkg::REG_VERTEX_COUNT, 16'hFFFF);
		add_random(40, 1);

		@(posedge clk);
		@(posedge clk);
		@(negedge clk);
		arst_n = 1;
		wait (stim_done && corner_q.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (failures == 0) begin
			$display("** triangle_face_normal: PASSED **");
		end else begin
			$display("** triangle_face_normal: FAILED **");
		end
		$finish;
	end

endmodule
